@@ hw/rtl/sha_pkg.sv @@
// Shared types, constants and round functions for the SHA-256 stream hasher.
`timescale 1ns / 1ps
package sha_pkg;

  localparam int unsigned BlockWords = 16;
  localparam int unsigned QueueSlots = 2;
  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [5:0] LenPos = 6'd56;

  typedef logic [31:0] word_t;

  // Write request from the front into the block queue.
  typedef struct packed {
    logic       en;
    logic [3:0] idx;
    word_t      data;
    logic       push;
    logic       fin;
  } blk_wr_t;

  localparam word_t InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t ror(input word_t x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t ssig0(input word_t x);
    ssig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(input word_t x);
    ssig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t bsig0(input word_t x);
    bsig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    bsig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

endpackage

@@ hw/rtl/sha_blkq.sv @@
// Two-slot block queue between the byte front and the compression core.
`timescale 1ns / 1ps
module sha_blkq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sha_pkg::blk_wr_t wr_i,
  output logic             full_o,
  output logic             avail_o,
  input  logic [3:0]       rd_idx_i,
  output sha_pkg::word_t   rd_data_o,
  output logic             rd_fin_o,
  input  logic             pop_i
);
  import sha_pkg::*;

  word_t      mem_q [QueueSlots*BlockWords];
  logic [1:0] fin_q;
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  word_t      rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[{wr_ptr_q, wr_i.idx}] <= wr_i.data;
    end
    rd_q <= mem_q[{rd_ptr_q, rd_idx_i}];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (wr_i.push) begin
        fin_q[wr_ptr_q] <= wr_i.fin;
        wr_ptr_q        <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, wr_i.push} - {1'b0, pop_i};
    end
  end

  assign full_o    = cnt_q[1];
  assign avail_o   = (cnt_q != 2'd0);
  assign rd_data_o = rd_q;
  assign rd_fin_o  = fin_q[rd_ptr_q];

endmodule

@@ hw/rtl/sha_front.sv @@
// Byte front: counts bytes, packs words, appends padding and length.
`timescale 1ns / 1ps
module sha_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       msg_byte_i,
  input  logic             byte_present_i,
  input  logic             end_of_message_i,
  input  logic             q_full_i,
  output sha_pkg::blk_wr_t wr_o
);
  import sha_pkg::*;

  localparam logic [1:0] StIn   = 2'd0;
  localparam logic [1:0] StMark = 2'd1;
  localparam logic [1:0] StZero = 2'd2;
  localparam logic [1:0] StLen  = 2'd3;

  logic [1:0]  st_q, st_d;
  logic [5:0]  pos_q;
  logic [63:0] bits_q, bits_d;
  logic [63:0] len_q;
  logic [2:0]  lcnt_q;
  logic [23:0] word_q;
  logic        take;
  logic        wr_en, wr_last;
  logic [7:0]  wr_byte;

  assign in_ready_o = (st_q == StIn) && !q_full_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    st_d    = st_q;
    bits_d  = bits_q;
    wr_en   = 1'b0;
    wr_last = 1'b0;
    wr_byte = '0;
    unique case (st_q)
      StIn: begin
        if (take) begin
          wr_en   = byte_present_i;
          wr_byte = msg_byte_i;
          if (byte_present_i) begin
            bits_d = bits_q + 64'd8;
          end
          if (end_of_message_i) begin
            st_d = StMark;
          end
        end
      end
      StMark: begin
        if (!q_full_i) begin
          wr_en   = 1'b1;
          wr_byte = PadMark;
          st_d    = StZero;
        end
      end
      StZero: begin
        if (!q_full_i) begin
          if (pos_q == LenPos) begin
            st_d = StLen;
          end else begin
            wr_en = 1'b1;
          end
        end
      end
      StLen: begin
        if (!q_full_i) begin
          wr_en   = 1'b1;
          wr_byte = len_q[63:56];
          if (lcnt_q == 3'd7) begin
            wr_last = 1'b1;
            bits_d  = '0;
            st_d    = StIn;
          end
        end
      end
      default: st_d = StIn;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= StIn;
      pos_q  <= '0;
      bits_q <= '0;
      lcnt_q <= '0;
    end else begin
      st_q   <= st_d;
      bits_q <= bits_d;
      if (wr_en) begin
        pos_q <= pos_q + 6'd1;
      end
      if (st_q == StLen && wr_en) begin
        lcnt_q <= lcnt_q + 3'd1;
      end
    end
  end

  // length latched when the mark goes in, shifted out top byte first
  always_ff @(posedge clk_i) begin
    if (st_q == StMark) begin
      len_q <= bits_q;
    end else if (st_q == StLen && wr_en) begin
      len_q <= {len_q[55:0], 8'h00};
    end
    if (wr_en) begin
      word_q <= {word_q[15:0], wr_byte};
    end
  end

  always_comb begin
    wr_o.en   = wr_en && (pos_q[1:0] == 2'd3);
    wr_o.idx  = pos_q[5:2];
    wr_o.data = {word_q, wr_byte};
    wr_o.push = wr_en && (pos_q == 6'd63);
    wr_o.fin  = wr_last;
  end

endmodule

@@ hw/rtl/sha_core.sv @@
// Compression core: one round per cycle, hash state and digest output.
`timescale 1ns / 1ps
module sha_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                avail_i,
  input  sha_pkg::word_t      rd_data_i,
  input  logic                rd_fin_i,
  output logic [3:0]          rd_idx_o,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sha_pkg::word_t      digest_word_o,
  output logic [2:0]          word_index_o,
  output logic                last_word_o
);
  import sha_pkg::*;

  localparam logic [2:0] CIdle  = 3'd0;
  localparam logic [2:0] CPrime = 3'd1;
  localparam logic [2:0] CRound = 3'd2;
  localparam logic [2:0] CAdd   = 3'd3;
  localparam logic [2:0] COut   = 3'd4;

  logic [2:0] st_q;
  logic [5:0] rnd_q;
  logic [2:0] oidx_q;
  word_t      h_q   [8];
  word_t      wk_q  [8];
  word_t      win_q [16];
  word_t      w_cur, t1, t2;

  always_comb begin
    if (rnd_q[5:4] == 2'd0) begin
      w_cur = rd_data_i;
    end else begin
      w_cur = win_q[0] + ssig0(win_q[1]) + win_q[9] + ssig1(win_q[14]);
    end
    t1 = wk_q[7] + bsig1(wk_q[4]) + ((wk_q[4] & wk_q[5]) ^ (~wk_q[4] & wk_q[6]))
         + RoundK[rnd_q] + w_cur;
    t2 = bsig0(wk_q[0]) + ((wk_q[0] & wk_q[1]) ^ (wk_q[0] & wk_q[2]) ^ (wk_q[1] & wk_q[2]));
  end

  assign rd_idx_o      = (st_q == CRound) ? rnd_q[3:0] + 4'd1 : 4'd0;
  assign pop_o         = (st_q == CAdd);
  assign out_valid_o   = (st_q == COut);
  assign digest_word_o = h_q[oidx_q];
  assign word_index_o  = oidx_q;
  assign last_word_o   = (oidx_q == 3'd7);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= CIdle;
      rnd_q  <= '0;
      oidx_q <= '0;
      h_q    <= InitH;
    end else begin
      unique case (st_q)
        CIdle: begin
          if (avail_i) begin
            st_q <= CPrime;
          end
        end
        CPrime: begin
          rnd_q <= '0;
          st_q  <= CRound;
        end
        CRound: begin
          rnd_q <= rnd_q + 6'd1;
          if (rnd_q == 6'd63) begin
            st_q <= CAdd;
          end
        end
        CAdd: begin
          for (int i = 0; i < 8; i++) begin
            h_q[i] <= h_q[i] + wk_q[i];
          end
          st_q <= rd_fin_i ? COut : CIdle;
        end
        COut: begin
          if (out_ready_i) begin
            oidx_q <= oidx_q + 3'd1;
            if (oidx_q == 3'd7) begin
              h_q  <= InitH;
              st_q <= CIdle;
            end
          end
        end
        default: st_q <= CIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == CPrime) begin
      wk_q <= h_q;
    end else if (st_q == CRound) begin
      wk_q[7] <= wk_q[6];
      wk_q[6] <= wk_q[5];
      wk_q[5] <= wk_q[4];
      wk_q[4] <= wk_q[3] + t1;
      wk_q[3] <= wk_q[2];
      wk_q[2] <= wk_q[1];
      wk_q[1] <= wk_q[0];
      wk_q[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[15] <= w_cur;
    end
  end

endmodule

@@ hw/rtl/sha256_stream_hash_unit.sv @@
// Top level of the SHA-256 byte stream hasher.
`timescale 1ns / 1ps
// SHA-256 over a byte stream. Each input request carries one byte (tuser[0]
// high) or none, and tlast closes the message, so a bare tlast request hashes
// the empty message. The front packs bytes into 32-bit words in a two-slot
// block queue and, on close, feeds 0x80, zero fill and the 64-bit big-endian
// bit length through the same byte path, one byte per cycle while a queue slot
// is free. The core runs the 64 rounds of a block at one round per cycle and,
// after the last block of a message, sends the eight digest words, index in
// tdata[34:32] and tlast on word seven. Bytes are taken at one per cycle while
// a queue slot is free, so the sustained rate is set by the core: roughly one
// byte per cycle on average. Closing a message takes the front through the
// mark, up to 63 zero bytes, one turn step and eight length bytes, plus queue
// stalls and the final one or two compressions.
module sha256_stream_hash_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] msg_byte
  input  logic [0:0]  s_axis_tuser,   // [0] byte_present
  input  logic        s_axis_tlast,   // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
  output logic        m_axis_tlast    // last_word
);
  import sha_pkg::*;

  blk_wr_t    wr;
  logic       q_full, q_avail, q_fin, q_pop;
  logic [3:0] rd_idx;
  word_t      rd_data, dword;
  logic [2:0] widx;

  sha_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .msg_byte_i       (s_axis_tdata),
    .byte_present_i   (s_axis_tuser[0]),
    .end_of_message_i (s_axis_tlast),
    .q_full_i         (q_full),
    .wr_o             (wr)
  );

  sha_blkq u_blkq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .full_o    (q_full),
    .avail_o   (q_avail),
    .rd_idx_i  (rd_idx),
    .rd_data_o (rd_data),
    .rd_fin_o  (q_fin),
    .pop_i     (q_pop)
  );

  sha_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .avail_i       (q_avail),
    .rd_data_i     (rd_data),
    .rd_fin_i      (q_fin),
    .rd_idx_o      (rd_idx),
    .pop_o         (q_pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .digest_word_o (dword),
    .word_index_o  (widx),
    .last_word_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {5'b0, widx, dword};

endmodule
